// File: rtl/xmds_pkg.sv
// Package for the member displacement scanner: sizes, codes, queue entry type
// and the instruction pattern check. Depends on nothing.
package xmds_pkg;

	localparam int DISP_LIMIT  = 8192;
	localparam int WORD_BITS   = 64;
	localparam int WIN_LEN     = 9;
	localparam int NUM_WORDS   = (DISP_LIMIT + WORD_BITS - 1) / WORD_BITS;
	localparam int DISP_W      = $clog2(DISP_LIMIT);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int FILL_W      = $clog2(WIN_LEN + 1);
	localparam int FUNC_W      = 2;
	localparam int READ_IDX_W  = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 2;

	typedef logic [7:0] cbyte_t;
	typedef cbyte_t [WIN_LEN-1:0] win_t;
	typedef logic [DISP_W-1:0] disp_t;
	typedef logic [WORD_IDX_W-1:0] widx_t;

	// Byte patterns of the instruction match
	localparam cbyte_t REX_MASK   = 8'hF0;
	localparam cbyte_t REX_VAL    = 8'h40;
	localparam cbyte_t OPC_ESC    = 8'h0F;
	localparam cbyte_t OPC_GRP1_B = 8'h80;
	localparam cbyte_t OPC_GRP1_V = 8'h81;
	localparam cbyte_t OPC_GRP1_S = 8'h83;
	localparam cbyte_t OPC_MOV_MB = 8'h88;
	localparam cbyte_t OPC_MOV_MV = 8'h89;
	localparam cbyte_t OPC_MOV_RB = 8'h8A;
	localparam cbyte_t OPC_MOV_RV = 8'h8B;
	localparam cbyte_t OPC_LEA    = 8'h8D;
	localparam cbyte_t OPC_MOV_IB = 8'hC6;
	localparam cbyte_t OPC_MOV_IV = 8'hC7;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [2:0] RM_SIB     = 3'd4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CODE  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_START = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		OP_MARK  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  m0_vld;
		disp_t                 m0;
		logic                  m1_vld;
		disp_t                 m1;
		logic [READ_IDX_W-1:0] rd_idx;
	} entry_t;

	function automatic logic opcode_listed(cbyte_t op);
		logic hit;
		unique case (op)
			OPC_GRP1_B, OPC_GRP1_V, OPC_GRP1_S,
			OPC_MOV_MB, OPC_MOV_MV, OPC_MOV_RB, OPC_MOV_RV,
			OPC_LEA, OPC_MOV_IB, OPC_MOV_IV: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Match at byte 0 of w; avail9 clear means only eight bytes are usable.
	// Returns {hit, displacement}; hit only for displacements 1..DISP_LIMIT-1.
	function automatic logic [DISP_W:0] check_pattern(win_t w, logic avail9);
		logic       rex;
		logic       ok;
		cbyte_t     op;
		cbyte_t     modrm;
		logic [3:0] mpos;
		logic [3:0] dpos;
		logic [31:0] v;
		rex  = (w[0] & REX_MASK) == REX_VAL;
		op   = rex ? w[1] : w[0];
		ok   = 1'b1;
		if (op == OPC_ESC) begin
			mpos = rex ? 4'd3 : 4'd2;
		end else if (opcode_listed(op)) begin
			mpos = rex ? 4'd2 : 4'd1;
		end else begin
			mpos = 4'd0;
			ok   = 1'b0;
		end
		modrm = w[mpos];
		ok    = ok && (modrm[7:6] == MOD_DISP32);
		dpos  = mpos + 4'd1 + {3'b000, modrm[2:0] == RM_SIB};
		ok    = ok && (avail9 || dpos <= 4'd4);
		v     = {w[dpos + 4'd3], w[dpos + 4'd2], w[dpos + 4'd1], w[dpos]};
		ok    = ok && (v[31:DISP_W] == '0) && (v[DISP_W-1:0] != '0);
		return {ok, v[DISP_W-1:0]};
	endfunction

endpackage

// File: rtl/xmds_if.sv
// Handshake channels of the scanner: request beats in, bitmap word beats out.
// Depends on xmds_pkg.
interface xmds_req_if;
	logic                            valid;
	logic                            ready;
	logic [xmds_pkg::FUNC_W-1:0]     func;
	logic [7:0]                      code_byte;
	logic                            last;
	logic [xmds_pkg::READ_IDX_W-1:0] word_index;
	modport source (output valid, func, code_byte, last, word_index, input ready);
	modport sink (input valid, func, code_byte, last, word_index, output ready);
endinterface

interface xmds_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [xmds_pkg::WORD_BITS-1:0]  bitmap_word;
	logic [xmds_pkg::READ_IDX_W-1:0] read_index;
	modport source (output valid, bitmap_word, read_index, input ready);
	modport sink (input valid, bitmap_word, read_index, output ready);
endinterface

// File: rtl/xmds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on xmds_pkg for default sizes.
module xmds_ram #(
	parameter int WIDTH = xmds_pkg::WORD_BITS,
	parameter int DEPTH = xmds_pkg::NUM_WORDS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/xmds_queue.sv
// Short FIFO of decoded operations between front and back end.
// Depends on xmds_pkg.
module xmds_queue #(
	parameter int DEPTH = xmds_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  xmds_pkg::entry_t  push_entry,
	output logic              push_ready,
	output logic              pop_valid,
	output xmds_pkg::entry_t  pop_entry,
	input  logic              pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	xmds_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("queue: push offered while full");
`endif

endmodule

// File: rtl/xmds_front.sv
// Front end: accepts request beats, keeps the nine-byte code window and
// matches displacement patterns. Depends on xmds_pkg and xmds_if.
module xmds_front (
	input  logic             clk,
	input  logic             arst_n,
	xmds_req_if.sink         req,
	input  logic             push_ready,
	output logic             push_valid,
	output xmds_pkg::entry_t push_entry
);

	localparam int DW = xmds_pkg::DISP_W;
	localparam int FW = xmds_pkg::FILL_W;

	xmds_pkg::win_t  win_q;
	xmds_pkg::win_t  win_n;
	xmds_pkg::win_t  tail_win;
	logic [FW-1:0]   fill_q;
	logic [FW-1:0]   fill_n;
	logic            accept;
	logic            is_code;
	logic            is_read;
	logic            is_start;
	logic            full;
	logic            hit0;
	logic            hit1;
	logic [DW:0]     chk0;
	logic [DW:0]     chk1;

	assign req.ready = push_ready;
	assign accept    = req.valid && push_ready;
	assign is_code   = req.func == xmds_pkg::FUNC_CODE;
	assign is_read   = req.func == xmds_pkg::FUNC_READ;
	assign is_start  = req.func == xmds_pkg::FUNC_START;

	always_comb begin
		win_n  = win_q;
		fill_n = fill_q;
		if (fill_q < FW'(xmds_pkg::WIN_LEN)) begin
			for (int i = 0; i < xmds_pkg::WIN_LEN; i++) begin
				if (FW'(i) == fill_q) begin
					win_n[i] = req.code_byte;
				end
			end
			fill_n = fill_q + 1'b1;
		end else begin
			// Window full: drop the oldest byte
			win_n = {req.code_byte, win_q[xmds_pkg::WIN_LEN-1:1]};
		end
	end

	assign full     = fill_n == FW'(xmds_pkg::WIN_LEN);
	// Offset eight bytes before the end of the function
	assign tail_win = full ? {8'h00, win_n[xmds_pkg::WIN_LEN-1:1]} : win_n;
	assign chk0     = xmds_pkg::check_pattern(win_n, 1'b1);
	assign chk1     = xmds_pkg::check_pattern(tail_win, 1'b0);
	assign hit0     = is_code && full && chk0[DW];
	assign hit1     = is_code && req.last && (fill_n >= FW'(xmds_pkg::WIN_LEN - 1))
		&& chk1[DW];

	always_comb begin
		push_entry.m0_vld = hit0;
		push_entry.m0     = chk0[DW-1:0];
		push_entry.m1_vld = hit1;
		push_entry.m1     = chk1[DW-1:0];
		push_entry.rd_idx = req.word_index;
		if (is_read) begin
			push_entry.op = xmds_pkg::OP_READ;
		end else if (is_start) begin
			push_entry.op = xmds_pkg::OP_CLEAR;
		end else begin
			push_entry.op = xmds_pkg::OP_MARK;
		end
	end

	assign push_valid = accept && (is_read || is_start || hit0 || hit1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (is_code) begin
				fill_q <= req.last ? '0 : fill_n;
			end else if (is_start) begin
				fill_q <= '0;
			end
		end
	end

	// Bytes at and above the fill level are never looked at
	always_ff @(posedge clk) begin
		if (accept && is_code) begin
			win_q <= win_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(xmds_pkg::WIN_LEN))
		else $error("front: fill level beyond window");
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_code && req.last) |=> (fill_q == '0))
		else $error("front: window not emptied after final byte");
`endif

endmodule

// File: rtl/xmds_back.sv
// Back end: applies mark, read and clear operations to the bitmap RAM and
// buffers read results. Depends on xmds_pkg, xmds_if and xmds_ram.
module xmds_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  xmds_pkg::entry_t pop_entry,
	output logic             pop_ready,
	xmds_rsp_if.source       rsp
);

	localparam int WB    = xmds_pkg::WORD_BITS;
	localparam int IW    = xmds_pkg::WORD_IDX_W;
	localparam int BW    = xmds_pkg::BIT_W;
	localparam int DW    = xmds_pkg::DISP_W;
	localparam int OD    = xmds_pkg::OUT_DEPTH;
	localparam int OCW   = $clog2(OD + 1);
	localparam int OPW   = (OD > 1) ? $clog2(OD) : 1;

	logic                  sub_q;
	logic                  two;
	logic                  use_m1;
	xmds_pkg::disp_t       cur_disp;
	logic                  issue;
	logic                  out_pop;
	logic                  out_room;
	logic                  rd_pending;
	logic [OCW-1:0]        occ;
	xmds_pkg::widx_t       raddr;

	logic                  vld_s2;
	xmds_pkg::op_t         op_s2;
	xmds_pkg::widx_t       word_s2;
	logic [BW-1:0]         bit_s2;

	logic [WB-1:0]         ram_rdata;
	logic [WB-1:0]         cur_word;
	logic [WB-1:0]         base;
	logic [WB-1:0]         new_word;
	logic                  we;
	logic [xmds_pkg::NUM_WORDS-1:0] valid_q;

	logic                  wr_vld_q;
	xmds_pkg::widx_t       wr_addr_q;
	logic [WB-1:0]         wr_data_q;

	logic [WB-1:0]         odata_q [OD];
	xmds_pkg::widx_t       oidx_q [OD];
	logic [OPW-1:0]        owptr_q;
	logic [OPW-1:0]        orptr_q;
	logic [OCW-1:0]        ocnt_q;
	logic                  out_push;

	// Issue: one RAM access per cycle unless a read waits for result buffer room, two for an entry that carries two marks
	assign two      = pop_entry.m0_vld && pop_entry.m1_vld;
	assign use_m1   = sub_q || !pop_entry.m0_vld;
	assign cur_disp = use_m1 ? pop_entry.m1 : pop_entry.m0;

	assign out_pop    = rsp.valid && rsp.ready;
	assign rd_pending = vld_s2 && (op_s2 == xmds_pkg::OP_READ);
	assign occ        = ocnt_q + OCW'(rd_pending);
	assign out_room   = (occ < OCW'(OD)) || out_pop;

	assign issue     = pop_valid && ((pop_entry.op != xmds_pkg::OP_READ) || out_room);
	assign pop_ready = issue && !((pop_entry.op == xmds_pkg::OP_MARK) && two && !sub_q);
	assign raddr     = (pop_entry.op == xmds_pkg::OP_READ) ?
		pop_entry.rd_idx[IW-1:0] : cur_disp[DW-1:BW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= issue;
			if (issue && (pop_entry.op == xmds_pkg::OP_MARK) && two) begin
				sub_q <= !sub_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s2   <= pop_entry.op;
			word_s2 <= raddr;
			bit_s2  <= cur_disp[BW-1:0];
		end
	end

	xmds_ram #(
		.WIDTH (WB),
		.DEPTH (xmds_pkg::NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (word_s2),
		.wdata (new_word),
		.re    (issue),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Forward the previous write: it lands on the same edge the read samples
	assign cur_word = (wr_vld_q && (wr_addr_q == word_s2)) ? wr_data_q : ram_rdata;
	assign base     = valid_q[word_s2] ? cur_word : '0;
	assign new_word = base | (WB'(1) << bit_s2);
	assign we       = vld_s2 && (op_s2 == xmds_pkg::OP_MARK);
	assign out_push = rd_pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			wr_vld_q <= 1'b0;
		end else begin
			if (vld_s2 && (op_s2 == xmds_pkg::OP_CLEAR)) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[word_s2] <= 1'b1;
			end
			if (we) begin
				wr_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wr_addr_q <= word_s2;
			wr_data_q <= new_word;
		end
	end

	// Result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (out_push) begin
				owptr_q <= (owptr_q == OPW'(OD - 1)) ? '0 : owptr_q + 1'b1;
			end
			if (out_pop) begin
				orptr_q <= (orptr_q == OPW'(OD - 1)) ? '0 : orptr_q + 1'b1;
			end
			unique case ({out_push, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			odata_q[owptr_q] <= base;
			oidx_q[owptr_q]  <= word_s2;
		end
	end

	assign rsp.valid       = ocnt_q != '0;
	assign rsp.bitmap_word = odata_q[orptr_q];
	assign rsp.read_index  = oidx_q[orptr_q];

`ifndef NO_ASSERTIONS
	a_out_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= OCW'(OD))
		else $error("back: result buffer overcommitted");
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && (op_s2 == xmds_pkg::OP_CLEAR)) |=> (valid_q == '0))
		else $error("back: valid bits survive a clear");
	a_second_mark: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (pop_valid && (pop_entry.op == xmds_pkg::OP_MARK)
			&& pop_entry.m0_vld && pop_entry.m1_vld))
		else $error("back: second mark step without a two-mark entry");
`endif

endmodule

// File: rtl/x86_member_displacement_scanner_top.sv
// Top level of the member displacement scanner.
// Depends on xmds_pkg, xmds_if, xmds_front, xmds_queue, xmds_back, xmds_ram.
//
// Usage:
//   req carries one beat per item: func 0 streams a code byte (last marks the
//   final byte of a function), func 1 asks for bitmap word word_index, func 2
//   starts a new function and clears the bitmap. func 3 is dropped.
//   rsp returns one beat, bitmap_word and read_index, for every func 1 beat,
//   in request order. Code, start and unused beats return nothing.
// Throughput: one req beat per cycle while the operation queue has room. A
//   final code byte that finds two displacements takes two RAM accesses in the
//   back end; every other operation takes one, so the back end sustains one
//   beat per cycle apart from those and from reads held for result buffer room.
// Read path: a read result passes the operation queue, the stage-two
//   registers and the result buffer before it turns valid on rsp; a displacement
//   is visible to reads issued on the next cycle.
// Stalls: when rsp is held off the two-entry result buffer fills, read
//   operations wait in the queue, and req.ready drops once the queue is full.
// Reset: arst_n empties the window, the queue and the result buffer and marks
//   every bitmap word invalid (reads return zero); no clearing pass is needed.
module x86_member_displacement_scanner_top #(
	parameter int QUEUE_DEPTH = xmds_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	xmds_req_if.sink   req,
	xmds_rsp_if.source rsp
);

	logic             push_valid;
	logic             push_ready;
	xmds_pkg::entry_t push_entry;
	logic             pop_valid;
	logic             pop_ready;
	xmds_pkg::entry_t pop_entry;

	// Accept beats, match patterns, turn each beat into at most one operation
	xmds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	// Decouple matching from the bitmap RAM
	xmds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	// Read-modify-write the bitmap and serve word reads
	xmds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule
